// ===== design/frame_peak_speech_detector_top_assert.svh =====
// Assertion macros shared by the checker files of the speech detector.
// Depends on signals named clk and rst in the scope of each use.
`ifndef FRAME_PEAK_SPEECH_DETECTOR_TOP_ASSERT_SVH
`define FRAME_PEAK_SPEECH_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define FPSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define FPSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers reset itself
`define FPSD_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fpsd_pkg.sv =====
// Package for the frame peak speech detector: types, codes and defaults.
// Used by the registers, the detector, the top level and its checker.
package fpsd_pkg;

  // configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [2:0] REG_ENTER_GAIN     = 3'd0;
  localparam logic [2:0] REG_EXIT_GAIN      = 3'd1;
  localparam logic [2:0] REG_ABSOLUTE_FLOOR = 3'd2;
  localparam logic [2:0] REG_ENTRY_HANGOVER = 3'd3;
  localparam logic [2:0] REG_ACTIVE_LIMIT   = 3'd4;
  localparam logic [2:0] REG_TRAIL_FRAMES   = 3'd5;

  localparam logic [31:0] RST_ENTER_GAIN     = 32'd49152;
  localparam logic [31:0] RST_EXIT_GAIN      = 32'd32768;
  localparam logic [31:0] RST_ABSOLUTE_FLOOR = 32'd0;
  localparam logic [15:0] RST_ENTRY_HANGOVER = 16'd0;
  localparam logic [15:0] RST_ACTIVE_LIMIT   = 16'd1000;
  localparam logic [15:0] RST_TRAIL_FRAMES   = 16'd0;

  // queue depths
  localparam int FRAME_DEPTH_DEF  = 4;
  localparam int RESULT_DEPTH_DEF = 2;

  // fixed point
  localparam int Q_SHIFT = 14;
  localparam logic [15:0] SHORT_SPEECH_FRAMES = 16'd9;

  // decision codes on the result channel
  localparam logic [1:0] DEC_SILENCE = 2'd0;
  localparam logic [1:0] DEC_SPEECH  = 2'd1;
  localparam logic [1:0] DEC_HOLD    = 2'd2;

  typedef enum logic [1:0] {
    MODE_SILENCE = 2'd0,
    MODE_ACTIVE  = 2'd1,
    MODE_HOLD    = 2'd2,
    MODE_TRAIL   = 2'd3
  } mode_t;

  typedef enum logic {
    BK_IDLE,
    BK_EVAL
  } back_state_t;

  typedef struct packed {
    logic [31:0] enter_gain;
    logic [31:0] exit_gain;
    logic [31:0] absolute_floor;
    logic [15:0] entry_hangover;
    logic [15:0] active_limit;
    logic [15:0] trail_frames;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  decision;
    logic [31:0] noise_level;
    logic [31:0] speech_level;
    logic [14:0] frame_peak;
  } result_t;

endpackage

// ===== design/fpsd_fifo.sv =====
// Small register queue used between front and back and on the result side.
// Depends on nothing but its parameters; DEPTH must be at least 2.
module fpsd_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/fpsd_regs.sv =====
// Configuration registers behind an APB-style port.
// Depends on fpsd_pkg for register indexes, reset values and cfg_t.
module fpsd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpsd_pkg::APB_AW-1:0] paddr,
  input  logic [fpsd_pkg::APB_DW-1:0] pwdata,
  output logic [fpsd_pkg::APB_DW-1:0] prdata,
  output fpsd_pkg::cfg_t              cfg
);
  import fpsd_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enter_gain     <= RST_ENTER_GAIN;
      cfg.exit_gain      <= RST_EXIT_GAIN;
      cfg.absolute_floor <= RST_ABSOLUTE_FLOOR;
      cfg.entry_hangover <= RST_ENTRY_HANGOVER;
      cfg.active_limit   <= RST_ACTIVE_LIMIT;
      cfg.trail_frames   <= RST_TRAIL_FRAMES;
    end else if (wr) begin
      unique case (idx)
        REG_ENTER_GAIN:     cfg.enter_gain     <= pwdata;
        REG_EXIT_GAIN:      cfg.exit_gain      <= pwdata;
        REG_ABSOLUTE_FLOOR: cfg.absolute_floor <= pwdata;
        REG_ENTRY_HANGOVER: cfg.entry_hangover <= pwdata[15:0];
        REG_ACTIVE_LIMIT:   cfg.active_limit   <= pwdata[15:0];
        REG_TRAIL_FRAMES:   cfg.trail_frames   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_ENTER_GAIN:     prdata = cfg.enter_gain;
      REG_EXIT_GAIN:      prdata = cfg.exit_gain;
      REG_ABSOLUTE_FLOOR: prdata = cfg.absolute_floor;
      REG_ENTRY_HANGOVER: prdata = {16'd0, cfg.entry_hangover};
      REG_ACTIVE_LIMIT:   prdata = {16'd0, cfg.active_limit};
      REG_TRAIL_FRAMES:   prdata = {16'd0, cfg.trail_frames};
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== design/fpsd_front.sv =====
// Front end: sample magnitude and frame peak, one sample per cycle unless full.
// Depends on nothing outside; feeds the frame queue with one peak per frame.
module fpsd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic signed [15:0] sample,
  input  logic               frame_last,
  input  logic               fq_full,
  output logic               full,
  output logic               fq_push,
  output logic [14:0]        fq_peak
);
  logic [14:0] running_peak;
  logic [14:0] mag;
  logic [14:0] neg_mag;
  logic        accept;

  assign full   = fq_full;
  assign accept = push && !fq_full;

  // absolute value, most negative sample saturates
  assign neg_mag = 15'(-sample);
  always_comb begin
    if (!sample[15]) begin
      mag = sample[14:0];
    end else if (sample[14:0] == '0) begin
      mag = '1;
    end else begin
      mag = neg_mag;
    end
  end

  assign fq_peak = (mag > running_peak) ? mag : running_peak;
  assign fq_push = accept && frame_last;

  // running peak, cleared at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak <= '0;
    end else if (fq_push) begin
      running_peak <= '0;
    end else if (accept) begin
      running_peak <= fq_peak;
    end
  end

endmodule

// ===== design/fpsd_back.sv =====
// Back end: four-mode detector with noise and speech level tracking.
// Depends on fpsd_pkg; takes a queued frame peak once the last is decided.
module fpsd_back (
  input  logic              clk,
  input  logic              rst,
  input  fpsd_pkg::cfg_t    cfg,
  input  logic              fq_empty,
  input  logic [14:0]       fq_peak,
  output logic              fq_pop,
  input  logic              rq_full,
  output logic              rq_push,
  output fpsd_pkg::result_t rq_data
);
  import fpsd_pkg::*;

  back_state_t state, state_next;
  mode_t       mode, mode_next;
  logic [31:0] noise_floor, noise_floor_next;
  logic [31:0] speech_lvl, speech_lvl_next;
  logic [15:0] hangover_left, hangover_left_next;
  logic [15:0] active_count, active_count_next;
  logic [15:0] hold_count, hold_count_next;
  logic [16:0] trail_count, trail_count_next;

  logic [14:0] peak;
  logic [31:0] thr_enter;
  logic [31:0] thr_exit;
  logic [63:0] prod_enter;
  logic [63:0] prod_exit;
  logic [31:0] pq;
  logic        starts;
  logic [40:0] nf_acc;
  logic [33:0] sl_acc;
  logic [31:0] nf_upd;
  logic [31:0] sl_upd;

  // threshold products from the current noise floor
  assign prod_enter = 64'(noise_floor) * 64'(cfg.enter_gain);
  assign prod_exit  = 64'(noise_floor) * 64'(cfg.exit_gain);

  // level smoothing: (255*n + pq) >> 8 and (3*l + pq) >> 2
  assign pq     = {3'd0, peak, 14'd0};
  assign nf_acc = {1'b0, noise_floor, 8'd0} - {9'd0, noise_floor} + {9'd0, pq};
  assign sl_acc = {2'd0, speech_lvl} + {1'b0, speech_lvl, 1'b0} + {2'd0, pq};
  assign nf_upd = nf_acc[39:8];
  assign sl_upd = sl_acc[33:2];
  assign starts = (pq > thr_enter) && (pq > cfg.absolute_floor);

  // sequencer and mode update
  always_comb begin
    state_next         = state;
    mode_next          = mode;
    noise_floor_next   = noise_floor;
    speech_lvl_next    = speech_lvl;
    hangover_left_next = hangover_left;
    active_count_next  = active_count;
    hold_count_next    = hold_count;
    trail_count_next   = trail_count;
    fq_pop             = 1'b0;
    rq_push            = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!fq_empty && !rq_full) begin
          fq_pop     = 1'b1;
          state_next = BK_EVAL;
        end
      end
      BK_EVAL: begin
        rq_push    = 1'b1;
        state_next = BK_IDLE;
        case (mode) inside
          MODE_SILENCE: begin
            if (starts) begin
              mode_next          = MODE_ACTIVE;
              hangover_left_next = cfg.entry_hangover;
              active_count_next  = '0;
            end else begin
              noise_floor_next = nf_upd;
            end
          end
          MODE_ACTIVE: begin
            if (pq < thr_exit) begin
              if (active_count > SHORT_SPEECH_FRAMES) begin
                mode_next        = MODE_TRAIL;
                hold_count_next  = active_count;
                trail_count_next = '0;
              end else begin
                mode_next       = MODE_SILENCE;
                hold_count_next = '0;
              end
            end else begin
              speech_lvl_next = sl_upd;
              if (hangover_left != '0) begin
                hangover_left_next = hangover_left - 1'b1;
              end else begin
                noise_floor_next = nf_upd;
              end
              if (active_count < cfg.active_limit) begin
                active_count_next = active_count + 1'b1;
              end
            end
          end
          MODE_HOLD, MODE_TRAIL: begin
            // trailing counts first, then the hold rules apply
            if (mode == MODE_TRAIL) begin
              trail_count_next = trail_count + 1'b1;
              if (trail_count_next > {1'b0, cfg.trail_frames}) begin
                mode_next = MODE_HOLD;
              end
            end
            if (starts) begin
              mode_next          = MODE_ACTIVE;
              hangover_left_next = cfg.entry_hangover;
            end else begin
              noise_floor_next = nf_upd;
              if (active_count != '0) begin
                active_count_next = active_count - 1'b1;
              end
              if (hold_count == '0) begin
                mode_next = MODE_SILENCE;
              end else begin
                hold_count_next = hold_count - 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  // result, trailing reported as speech
  always_comb begin
    case (mode_next)
      MODE_SILENCE: rq_data.decision = DEC_SILENCE;
      MODE_HOLD:    rq_data.decision = DEC_HOLD;
      default:      rq_data.decision = DEC_SPEECH;
    endcase
    rq_data.noise_level  = noise_floor_next;
    rq_data.speech_level = speech_lvl_next;
    rq_data.frame_peak   = peak;
  end

  // frame operands, captured when a peak is taken
  always_ff @(posedge clk) begin
    if (fq_pop) begin
      peak      <= fq_peak;
      thr_enter <= prod_enter[Q_SHIFT +: 32];
      thr_exit  <= prod_exit[Q_SHIFT +: 32];
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      mode          <= MODE_SILENCE;
      noise_floor   <= '0;
      speech_lvl    <= '0;
      hangover_left <= '0;
      active_count  <= '0;
      hold_count    <= '0;
      trail_count   <= '0;
    end else begin
      state         <= state_next;
      mode          <= mode_next;
      noise_floor   <= noise_floor_next;
      speech_lvl    <= speech_lvl_next;
      hangover_left <= hangover_left_next;
      active_count  <= active_count_next;
      hold_count    <= hold_count_next;
      trail_count   <= trail_count_next;
    end
  end

endmodule

// ===== design/frame_peak_speech_detector_top.sv =====
// Frame peak speech detector: samples in, one decision per frame out.
// Channels: push/full carry PCM samples and a frame-end flag; empty/pop
// carry one request per frame: decision, noise level, speech level, peak.
// Registers sit on an APB-style port at byte address 4*index; write them
// only while no frame is in flight.
// Samples are taken one per cycle while full is low. The frame-end
// sample enters a small frame queue; the detector takes each peak in a
// step that forms the threshold products from the noise floor and a
// step that decides and updates, then writes the result queue.
// Frames of two or more samples keep a sustained rate of one sample
// per cycle while the receiver keeps up; back-to-back single-sample
// frames run slower, limited by the detector's multiply-then-compare
// loop on the noise floor.
// When the receiver stalls, results wait in the result queue and the
// detector stops; full rises once the frame queue has no room.
// Reset clears the queues, the running peak, the detector's mode, levels
// and counters, sets the registers to defaults; empty is high after reset.
// Depends on fpsd_pkg, fpsd_regs, fpsd_front, fpsd_fifo and fpsd_back.
module frame_peak_speech_detector_top #(
  parameter int FRAME_DEPTH  = fpsd_pkg::FRAME_DEPTH_DEF,
  parameter int RESULT_DEPTH = fpsd_pkg::RESULT_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic signed [15:0]          sample,
  input  logic                        frame_last,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  decision,
  output logic [31:0]                 noise_level,
  output logic [31:0]                 speech_level,
  output logic [14:0]                 frame_peak,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpsd_pkg::APB_AW-1:0] paddr,
  input  logic [fpsd_pkg::APB_DW-1:0] pwdata,
  output logic [fpsd_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import fpsd_pkg::*;

  cfg_t        cfg;
  logic        fq_push;
  logic [14:0] fq_wr_peak;
  logic [14:0] fq_rd_peak;
  logic        fq_full;
  logic        fq_empty;
  logic        fq_pop;
  logic        rq_push;
  logic        rq_full;
  result_t     rq_wr;
  result_t     rq_rd;

  assign pready = 1'b1;

  // configuration
  fpsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sample side
  fpsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .sample     (sample),
    .frame_last (frame_last),
    .fq_full    (fq_full),
    .full       (full),
    .fq_push    (fq_push),
    .fq_peak    (fq_wr_peak)
  );

  // frame peaks waiting for the detector
  fpsd_fifo #(
    .WIDTH (15),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_data (fq_wr_peak),
    .rd_en   (fq_pop),
    .rd_data (fq_rd_peak),
    .full    (fq_full),
    .empty   (fq_empty)
  );

  // detector
  fpsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fq_empty (fq_empty),
    .fq_peak  (fq_rd_peak),
    .fq_pop   (fq_pop),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_data  (rq_wr)
  );

  // results waiting for the receiver
  fpsd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rq_push),
    .wr_data (rq_wr),
    .rd_en   (pop),
    .rd_data (rq_rd),
    .full    (rq_full),
    .empty   (empty)
  );

  assign decision     = rq_rd.decision;
  assign noise_level  = rq_rd.noise_level;
  assign speech_level = rq_rd.speech_level;
  assign frame_peak   = rq_rd.frame_peak;

endmodule

// ===== design/fpsd_checker.sv =====
// Port-level checks for the speech detector, bound to the top level.
// Depends on fpsd_pkg and frame_peak_speech_detector_top_assert.svh.
`include "frame_peak_speech_detector_top_assert.svh"

module fpsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  decision,
  input logic [31:0] noise_level
);
  import fpsd_pkg::*;

  // reset leaves both channels drained and open
  `FPSD_ASSERT_RST(a_reset_clear, rst, empty && !full, "queues not clear after reset")

  // a waiting request holds while the receiver stalls
  `FPSD_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(decision) && $stable(noise_level), "result changed under stall")

  // only the three decision codes ever show
  `FPSD_ASSERT_NOW(a_dec_code, !empty, decision == DEC_SILENCE || decision == DEC_SPEECH || decision == DEC_HOLD, "bad decision code")

  // the frame queue fills only through accepted samples
  `FPSD_ASSERT_NOW(a_full_cause, $rose(full), $past(push), "full rose without a request")

endmodule

bind frame_peak_speech_detector_top fpsd_checker u_fpsd_checker (.*);
